// File: rtl/ps2s1_pkg.sv
// Shared types, scancode constants and the set 1 to HID usage table.
// No dependencies; the converter and the decoder refer to this package by scoped names.
package ps2s1_pkg;

    localparam logic [7:0] SC_PREFIX = 8'hE0;
    localparam logic [7:0] SC_LALT   = 8'h38;
    localparam logic [7:0] SC_LCTRL  = 8'h1D;
    localparam logic [7:0] SC_LSHIFT = 8'h2A;
    localparam logic [7:0] SC_RSHIFT = 8'h36;
    localparam logic [7:0] SC_BREAK  = 8'h80;
    localparam logic [7:0] SC_DIGIT1 = 8'h02;
    localparam logic [7:0] SC_DIGIT9 = 8'h0A;

    localparam logic [7:0] MOD_LCTRL  = 8'h01;
    localparam logic [7:0] MOD_LSHIFT = 8'h02;
    localparam logic [7:0] MOD_LALT   = 8'h04;
    localparam logic [7:0] MOD_RCTRL  = 8'h10;
    localparam logic [7:0] MOD_RSHIFT = 8'h20;
    localparam logic [7:0] MOD_RALT   = 8'h40;

    localparam logic KIND_KEY   = 1'b0;
    localparam logic KIND_FOCUS = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] usage;
        logic [7:0] modifiers;
        logic [3:0] focus_target;
    } t_event;

    typedef struct packed {
        logic       emit;
        t_event     evt;
        logic       ext_next;
        logic [7:0] mod_next;
    } t_decode;

    // Set 1 make code (low seven bits) to HID usage; zero means unmapped.
    function automatic logic [7:0] usage_of(input logic [6:0] code);
        logic [7:0] u;
        case (code)
            7'h01: u = 8'h29;
            7'h02: u = 8'h1E; 7'h03: u = 8'h1F; 7'h04: u = 8'h20;
            7'h05: u = 8'h21; 7'h06: u = 8'h22; 7'h07: u = 8'h23;
            7'h08: u = 8'h24; 7'h09: u = 8'h25; 7'h0A: u = 8'h26;
            7'h0B: u = 8'h27; 7'h0C: u = 8'h2D; 7'h0D: u = 8'h2E;
            7'h0E: u = 8'h2A; 7'h0F: u = 8'h2B;
            7'h10: u = 8'h14; 7'h11: u = 8'h1A; 7'h12: u = 8'h08;
            7'h13: u = 8'h15; 7'h14: u = 8'h17; 7'h15: u = 8'h1C;
            7'h16: u = 8'h18; 7'h17: u = 8'h0C; 7'h18: u = 8'h12;
            7'h19: u = 8'h13; 7'h1A: u = 8'h2F; 7'h1B: u = 8'h30;
            7'h1C: u = 8'h28;
            7'h1E: u = 8'h04; 7'h1F: u = 8'h16; 7'h20: u = 8'h07;
            7'h21: u = 8'h09; 7'h22: u = 8'h0A; 7'h23: u = 8'h0B;
            7'h24: u = 8'h0D; 7'h25: u = 8'h0E; 7'h26: u = 8'h0F;
            7'h27: u = 8'h33; 7'h28: u = 8'h34; 7'h29: u = 8'h35;
            7'h2B: u = 8'h31;
            7'h2C: u = 8'h1D; 7'h2D: u = 8'h1B; 7'h2E: u = 8'h06;
            7'h2F: u = 8'h19; 7'h30: u = 8'h05; 7'h31: u = 8'h11;
            7'h32: u = 8'h10; 7'h33: u = 8'h36; 7'h34: u = 8'h37;
            7'h35: u = 8'h38;
            7'h39: u = 8'h2C;
            7'h56: u = 8'h64;
            default: u = 8'h00;
        endcase
        return u;
    endfunction

endpackage

// File: rtl/ps2s1_if.sv
// Valid/ready channel interfaces: scancode byte in, key or focus event out.
// Has no dependencies; the event field widths are declared directly in each interface.
interface ps2s1_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

interface ps2s1_event_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] usage;
    logic [7:0] modifiers;
    logic [3:0] focus_target;

    modport source (output valid, output kind, output usage, output modifiers,
                    output focus_target, input ready);
    modport sink   (input valid, input kind, input usage, input modifiers,
                    input focus_target, output ready);
endinterface

// File: rtl/ps2s1_scancode_to_hid.sv
// Pipeline: a byte accepted into the input register is decoded out of it, and its event is
// loaded into the result register when the byte advances, which waits on a stalled sink;
// bytes that give no event leave no output beat.
// Throughput: one byte per cycle while the sink keeps up; while an event waits on a
// stalled sink, hold one more byte in the input register, then drop input ready.
// Reset (synchronous, active low): prefix flag, modifier bits and both valids clear.
module ps2_set1_scancode_to_hid (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ps2s1_byte_if.sink           i_scan,
    ps2s1_event_if.source        o_event
);

    // input stage: one held byte
    logic                 r_in_valid;
    logic [7:0]           r_in_byte;

    // decoder state
    logic                 r_ext;
    logic [7:0]           r_mods;

    // result stage
    logic                 r_out_valid;
    ps2s1_pkg::t_event    r_out_evt;

    ps2s1_pkg::t_decode   w_dec;
    logic                 w_advance;
    logic                 w_take;

    ps2s1_decode u_decode (
        .i_ext  (r_ext),
        .i_mods (r_mods),
        .i_byte (r_in_byte),
        .o_dec  (w_dec)
    );

    // Advance the held byte whenever the result register is free or draining
    // this cycle; a byte without an event waits the same way.
    assign w_advance = r_in_valid && (!r_out_valid || o_event.ready);
    assign i_scan.ready = !r_in_valid || w_advance;
    assign w_take = i_scan.valid && i_scan.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_scan.ready) begin
            r_in_valid <= i_scan.valid;
        end
        if (w_take) begin
            r_in_byte <= i_scan.scan_byte;
        end
    end

    // Update prefix flag and modifiers exactly once per decoded byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext  <= 1'b0;
            r_mods <= 8'h00;
        end else if (w_advance) begin
            r_ext  <= w_dec.ext_next;
            r_mods <= w_dec.mod_next;
        end
    end

    // Hold the result until the sink takes it; load a new one on advance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_dec.emit;
        end else if (o_event.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance && w_dec.emit) begin
            r_out_evt <= w_dec.evt;
        end
    end

    assign o_event.valid        = r_out_valid;
    assign o_event.kind         = r_out_evt.kind;
    assign o_event.usage        = r_out_evt.usage;
    assign o_event.modifiers    = r_out_evt.modifiers;
    assign o_event.focus_target = r_out_evt.focus_target;

endmodule

// File: rtl/ps2s1_decode.sv
// Combinational decode of one scancode byte against the prefix flag and modifiers.
// Depends on ps2s1_pkg for constants, the usage table and the decode struct.
module ps2s1_decode (
    input  logic                 i_ext,
    input  logic [7:0]           i_mods,
    input  logic [7:0]           i_byte,
    output ps2s1_pkg::t_decode   o_dec
);

    logic [7:0] w_usage;

    assign w_usage = ps2s1_pkg::usage_of(i_byte[6:0]);

    always_comb begin
        o_dec          = '0;
        o_dec.ext_next = 1'b0;
        o_dec.mod_next = i_mods;
        if (i_byte == ps2s1_pkg::SC_PREFIX) begin
            o_dec.ext_next = 1'b1;
        end else if (i_ext) begin
            // extended: only right Alt and right Ctrl matter
            if (i_byte == ps2s1_pkg::SC_LALT) begin
                o_dec.mod_next = i_mods | ps2s1_pkg::MOD_RALT;
            end else if (i_byte == (ps2s1_pkg::SC_LALT | ps2s1_pkg::SC_BREAK)) begin
                o_dec.mod_next = i_mods & ~ps2s1_pkg::MOD_RALT;
            end else if (i_byte == ps2s1_pkg::SC_LCTRL) begin
                o_dec.mod_next = i_mods | ps2s1_pkg::MOD_RCTRL;
            end else if (i_byte == (ps2s1_pkg::SC_LCTRL | ps2s1_pkg::SC_BREAK)) begin
                o_dec.mod_next = i_mods & ~ps2s1_pkg::MOD_RCTRL;
            end
        end else if (i_byte == ps2s1_pkg::SC_LSHIFT) begin
            o_dec.mod_next = i_mods | ps2s1_pkg::MOD_LSHIFT;
        end else if (i_byte == (ps2s1_pkg::SC_LSHIFT | ps2s1_pkg::SC_BREAK)) begin
            o_dec.mod_next = i_mods & ~ps2s1_pkg::MOD_LSHIFT;
        end else if (i_byte == ps2s1_pkg::SC_RSHIFT) begin
            o_dec.mod_next = i_mods | ps2s1_pkg::MOD_RSHIFT;
        end else if (i_byte == (ps2s1_pkg::SC_RSHIFT | ps2s1_pkg::SC_BREAK)) begin
            o_dec.mod_next = i_mods & ~ps2s1_pkg::MOD_RSHIFT;
        end else if (i_byte == ps2s1_pkg::SC_LCTRL) begin
            o_dec.mod_next = i_mods | ps2s1_pkg::MOD_LCTRL;
        end else if (i_byte == (ps2s1_pkg::SC_LCTRL | ps2s1_pkg::SC_BREAK)) begin
            o_dec.mod_next = i_mods & ~ps2s1_pkg::MOD_LCTRL;
        end else if (i_byte == ps2s1_pkg::SC_LALT) begin
            o_dec.mod_next = i_mods | ps2s1_pkg::MOD_LALT;
        end else if (i_byte == (ps2s1_pkg::SC_LALT | ps2s1_pkg::SC_BREAK)) begin
            o_dec.mod_next = i_mods & ~ps2s1_pkg::MOD_LALT;
        end else if ((i_byte & ps2s1_pkg::SC_BREAK) != 8'h00) begin
            // drop other break codes
        end else if (((i_mods & ps2s1_pkg::MOD_LALT) != 8'h00)
                     && (i_byte >= ps2s1_pkg::SC_DIGIT1)
                     && (i_byte <= ps2s1_pkg::SC_DIGIT9)) begin
            o_dec.emit             = 1'b1;
            o_dec.evt.kind         = ps2s1_pkg::KIND_FOCUS;
            o_dec.evt.focus_target = i_byte[3:0] - 4'd1;
        end else if (w_usage != 8'h00) begin
            o_dec.emit          = 1'b1;
            o_dec.evt.kind      = ps2s1_pkg::KIND_KEY;
            o_dec.evt.usage     = w_usage;
            o_dec.evt.modifiers = i_mods;
        end
    end

endmodule
